@@ sv/tccw_pkg.sv @@
// Shared types, constants and helpers for the text console cell writer.
// Used by tccw_ram, tccw_seq and text_console_cell_writer; no dependencies.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int IDX_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_NEWLINE,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_WRITE,
    ST_READ_ADDR,
    ST_READ_WAIT,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [IDX_W-1:0]  cursor_index;
    logic [BYTE_W-1:0] cell_code;
    logic [BYTE_W-1:0] cell_color;
  } rsp_t;

  // One write port and one read port of the cell store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

@@ sv/tccw_ram.sv @@
// Cell store of the text console: one write port, one registered read port.
// Depends on tccw_pkg for the store size and the port struct.
`timescale 1ns / 1ps

module tccw_ram
  import tccw_pkg::*;
(
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [CELL_W-1:0] rd_data_o
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_o <= mem[req_i.raddr];
    end
  end

endmodule

@@ sv/tccw_seq.sv @@
// Sequencer of the text console: cursor registers, a shared cell pointer that
// walks the store for scroll, clear and reset, and the single-cell accesses.
// Depends on tccw_pkg; drives the ports of tccw_ram.
`timescale 1ns / 1ps

module tccw_seq
  import tccw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_t              req_i,
  input  logic [BYTE_W-1:0] text_color_i,
  input  logic              out_free_i,
  input  logic [CELL_W-1:0] rd_data_i,
  output logic              idle_o,
  output logic              done_o,
  output rsp_t              rsp_o,
  output ram_req_t          ram_o
);

  st_e               state_q, state_d;
  req_t              req_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] ptr_q;
  logic              char_pend_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [BYTE_W-1:0] code_q;
  logic [BYTE_W-1:0] color_q;

  logic last_row;
  logic wrap_pend;
  logic read_ok;
  logic ptr_last;

  assign last_row  = (row_q >= ROW_W'(ROWS - 1));
  assign wrap_pend = (col_q >= COL_W'(COLUMNS));
  assign read_ok   = (req_q.read_row < ROW_W'(ROWS)) && (req_q.read_col < COL_W'(COLUMNS));
  assign ptr_last  = (ptr_q == ADDR_W'(CELLS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (ptr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (req_q.op)
          OP_PUT: begin
            if (req_q.char_code == NEWLINE_CODE || wrap_pend) begin
              state_d = ST_NEWLINE;
            end else begin
              state_d = ST_WRITE;
            end
          end
          OP_DELETE: state_d = ST_WRITE;
          OP_CLEAR:  state_d = ST_FILL;
          OP_READ:   state_d = read_ok ? ST_READ_ADDR : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_NEWLINE: begin
        if (last_row) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = char_pend_q ? ST_WRITE : ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (ptr_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:     state_d = ST_FILL;
      ST_FILL: begin
        if (ptr_last) state_d = char_pend_q ? ST_WRITE : ST_DONE;
      end
      ST_WRITE:     state_d = ST_DONE;
      ST_READ_ADDR: state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory port.
  always_comb begin
    ram_o       = '0;
    idle_o      = (state_q == ST_IDLE);
    done_o      = (state_q == ST_DONE) && out_free_i;
    if (wr_pend_q) begin
      // A cell read during the scroll moves up by one row.
      ram_o.we    = 1'b1;
      ram_o.waddr = wr_addr_q;
      ram_o.wdata = rd_data_i;
    end
    case (state_q)
      ST_INIT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ptr_q;
        ram_o.wdata = '0;
      end
      ST_SCROLL: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ptr_q;
      end
      ST_FILL: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ptr_q;
        ram_o.wdata = {text_color_i, BLANK_CODE};
      end
      ST_WRITE: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = cell_addr(row_q, col_q);
        ram_o.wdata = (req_q.op == OP_PUT) ? {text_color_i, req_q.char_code}
                                           : {text_color_i, BLANK_CODE};
      end
      ST_READ_ADDR: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = cell_addr(req_q.read_row, req_q.read_col);
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.cursor_row   = row_q;
  assign rsp_o.cursor_col   = col_q;
  assign rsp_o.cursor_index = IDX_W'(cell_addr(row_q, col_q));
  assign rsp_o.cell_code    = code_q;
  assign rsp_o.cell_color   = color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      char_pend_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          ptr_q <= ptr_q + ADDR_W'(1);
        end
        ST_DECODE: begin
          char_pend_q <= 1'b0;
          case (req_q.op)
            OP_PUT: begin
              char_pend_q <= (req_q.char_code != NEWLINE_CODE);
            end
            OP_DELETE: begin
              if (col_q == '0) begin
                if (row_q != '0) begin
                  row_q <= row_q - ROW_W'(1);
                  col_q <= COL_W'(COLUMNS - 1);
                end
              end else begin
                col_q <= col_q - COL_W'(1);
              end
            end
            OP_CLEAR: begin
              row_q <= '0;
              col_q <= '0;
              ptr_q <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_NEWLINE: begin
          col_q <= '0;
          if (last_row) begin
            ptr_q <= ADDR_W'(COLUMNS);
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end
        ST_SCROLL: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= ptr_q - ADDR_W'(COLUMNS);
          ptr_q     <= ptr_q + ADDR_W'(1);
        end
        ST_DRAIN: begin
          ptr_q <= ADDR_W'((ROWS - 1) * COLUMNS);
        end
        ST_FILL: begin
          ptr_q <= ptr_q + ADDR_W'(1);
        end
        ST_WRITE: begin
          if (req_q.op == OP_PUT) col_q <= col_q + COL_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Request and read-back payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q <= req_i;
    end
    if (state_q == ST_DECODE) begin
      code_q  <= '0;
      color_q <= '0;
    end else if (state_q == ST_READ_WAIT) begin
      code_q  <= rd_data_i[BYTE_W-1:0];
      color_q <= rd_data_i[CELL_W-1:BYTE_W];
    end
  end

  // The scroll writes only cells that have already been read.
  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (wr_addr_q < ptr_q))
    else $error("scroll write overtakes read pointer");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < ROW_W'(ROWS)) && (col_q <= COL_W'(COLUMNS)))
    else $error("cursor out of range");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!ram_o.we && !wr_pend_q))
    else $error("store written while idle");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("result handed over without return to idle");

endmodule

@@ sv/text_console_cell_writer.sv @@
// Text console cell writer: 80 by 25 cell store with cursor, put-char, delete,
// clear and read operations.
// Requests enter on in_valid_i / in_stall_o with a req_t payload; results
// leave on out_valid_o / out_stall_i with an rsp_t payload. A transfer takes
// place at a rising edge where valid is high and stall is low. Every request
// produces exactly one result carrying the cursor after the operation and,
// for a read, the addressed cell.
// Requests are processed one at a time. A clear, a newline that scrolls and
// a wrapping put on the last row walk the store one cell per cycle through
// its one write and one registered read port; the other operations touch at
// most one cell. The sequencer returns to idle as the result register is
// loaded and then accepts the next request. While that register is stalled
// the next request is still processed, but its result waits in the
// sequencer, with in_stall_o high, until the register is taken. After reset
// the store is swept to zero with in_stall_o high. text_color_we_i writes
// the color register; it is meant to be written only while the block is
// idle.
// Depends on tccw_pkg, tccw_seq and tccw_ram.
`timescale 1ns / 1ps

module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_data_o,
  input  logic              text_color_we_i,
  input  logic [BYTE_W-1:0] text_color_i
);

  logic [BYTE_W-1:0] color_q;
  logic              out_valid_q;
  rsp_t              out_data_q;
  logic              out_free;
  logic              seq_idle;
  logic              seq_done;
  logic              start;
  rsp_t              seq_rsp;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (text_color_we_i) color_q <= text_color_i;
      if (seq_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) out_data_q <= seq_rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tccw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (in_data_i),
    .text_color_i (color_q),
    .out_free_i   (out_free),
    .rd_data_i    (ram_rdata),
    .idle_o       (seq_idle),
    .done_o       (seq_done),
    .rsp_o        (seq_rsp),
    .ram_o        (ram_req)
  );

  tccw_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rdata)
  );

endmodule
